// File: sv/brle_pkg.sv
// Shared constants and types for the bilevel run-length encoder.
package brle_pkg;

	localparam int MEDIUM_WIDTH  = 128;
	localparam int MEDIUM_HEIGHT = 96;
	localparam int HIGH_WIDTH    = 256;
	localparam int HIGH_HEIGHT   = 192;
	localparam int MAX_RUN       = 94;

	localparam int FRAME_MEDIUM = MEDIUM_WIDTH * MEDIUM_HEIGHT;
	localparam int FRAME_HIGH   = HIGH_WIDTH * HIGH_HEIGHT;
	localparam int FRAME_MAX    = (FRAME_HIGH > FRAME_MEDIUM) ? FRAME_HIGH : FRAME_MEDIUM;
	localparam int IDX_W        = $clog2(FRAME_MAX + 1);
	localparam int RUN_W        = $clog2(MAX_RUN + 1);

	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam logic [7:0] CHAR_G   = 8'h47;
	localparam logic [7:0] CHAR_M   = 8'h4D;
	localparam logic [7:0] CHAR_H   = 8'h48;
	localparam logic [7:0] CHAR_N   = 8'h4E;
	localparam logic [7:0] RUN_BASE = 8'h20;
	localparam logic [7:0] RUN_FULL = RUN_BASE + 8'(MAX_RUN);

	// Byte slots of one pixel's output, in stream order.
	localparam int STEP_HDR_ESC = 0;
	localparam int STEP_HDR_G   = 1;
	localparam int STEP_HDR_MOD = 2;
	localparam int STEP_MID_RUN = 3;
	localparam int STEP_MID_GAP = 4;
	localparam int STEP_TRL_RUN = 5;
	localparam int STEP_TRL_ESC = 6;
	localparam int STEP_TRL_G   = 7;
	localparam int STEP_TRL_N   = 8;
	localparam int NSTEPS       = 9;
	localparam int STEP_W       = $clog2(NSTEPS);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [NSTEPS-1:0] step_mask_t;

	// One queued command: which bytes to send and the run bytes themselves.
	typedef struct packed {
		step_mask_t steps;
		logic       mode;
		logic [7:0] mid_byte;
		logic [7:0] trl_byte;
	} brle_cmd_t;

endpackage

// File: sv/brle_front.sv
// Front end: accepts pixels, tracks runs and frame position, builds byte commands.
module brle_front import brle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mode,
	input  logic      pix_valid,
	output logic      pix_ready,
	input  logic      dark,
	input  logic      q_full,
	output logic      push,
	output brle_cmd_t cmd
);

	logic             colour_q;
	logic [RUN_W-1:0] run_q;
	logic [IDX_W-1:0] index_q;

	logic             accept;
	logic             same;
	logic             overflow;
	logic             frame_done;
	logic [IDX_W-1:0] idx_next;
	logic [RUN_W-1:0] run_next;

	assign pix_ready = !q_full;
	assign accept    = pix_valid && pix_ready;

	always_comb begin
		same       = (dark == colour_q);
		overflow   = same && (run_q >= RUN_W'(MAX_RUN));
		idx_next   = index_q + IDX_W'(1);
		frame_done = mode ? (idx_next >= IDX_W'(FRAME_HIGH))
		                  : (idx_next >= IDX_W'(FRAME_MEDIUM));
		if (same && !overflow) begin
			run_next = run_q + RUN_W'(1);
		end else begin
			run_next = RUN_W'(1);
		end

		cmd.steps               = '0;
		cmd.steps[STEP_HDR_ESC] = (index_q == '0);
		cmd.steps[STEP_HDR_G]   = (index_q == '0);
		cmd.steps[STEP_HDR_MOD] = (index_q == '0);
		cmd.steps[STEP_MID_RUN] = !same || overflow;
		cmd.steps[STEP_MID_GAP] = overflow;
		cmd.steps[STEP_TRL_RUN] = frame_done;
		cmd.steps[STEP_TRL_ESC] = frame_done;
		cmd.steps[STEP_TRL_G]   = frame_done;
		cmd.steps[STEP_TRL_N]   = frame_done;
		cmd.mode                = mode;
		cmd.mid_byte            = overflow ? RUN_FULL : (RUN_BASE + 8'(run_q));
		cmd.trl_byte            = RUN_BASE + 8'(run_next);
	end

	assign push = accept && (|cmd.steps);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q <= 1'b1;
			run_q    <= '0;
			index_q  <= '0;
		end else if (accept) begin
			if (frame_done) begin
				colour_q <= 1'b1;
				run_q    <= '0;
				index_q  <= '0;
			end else begin
				colour_q <= same ? colour_q : ~colour_q;
				run_q    <= run_next;
				index_q  <= idx_next;
			end
		end
	end

endmodule

// File: sv/brle_queue.sv
// Short command queue between the front end and the byte sequencer.
module brle_queue import brle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  brle_cmd_t push_cmd,
	output logic      full,
	output logic      head_valid,
	input  logic      pop,
	output brle_cmd_t head
);

	brle_cmd_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (!push && pop) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// File: sv/brle_back.sv
// Back end: walks each queued command and sends its bytes, one beat per cycle while byte_ready does not stall it.
module brle_back import brle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	output logic       pop,
	input  brle_cmd_t  head,
	output logic       byte_valid,
	input  logic       byte_ready,
	output logic [7:0] out_byte,
	output logic       last,
	output logic       frame_end
);

	step_mask_t        done_q;
	logic              byte_valid_q;
	logic [7:0]        out_byte_q;
	logic              last_q;
	logic              frame_end_q;

	step_mask_t        remain;
	logic [STEP_W-1:0] cur;
	logic              final_step;
	logic              emit;
	logic [7:0]        cur_byte;

	always_comb begin
		remain = head.steps & ~done_q;
		cur    = '0;
		for (int i = NSTEPS - 1; i >= 0; i--) begin
			if (remain[i]) begin
				cur = STEP_W'(i);
			end
		end
		final_step = ((remain >> cur) == step_mask_t'(1));
		case (cur)
			STEP_W'(STEP_HDR_ESC): cur_byte = ESC_BYTE;
			STEP_W'(STEP_HDR_G):   cur_byte = CHAR_G;
			STEP_W'(STEP_HDR_MOD): cur_byte = head.mode ? CHAR_H : CHAR_M;
			STEP_W'(STEP_MID_RUN): cur_byte = head.mid_byte;
			STEP_W'(STEP_MID_GAP): cur_byte = RUN_BASE;
			STEP_W'(STEP_TRL_RUN): cur_byte = head.trl_byte;
			STEP_W'(STEP_TRL_ESC): cur_byte = ESC_BYTE;
			STEP_W'(STEP_TRL_G):   cur_byte = CHAR_G;
			STEP_W'(STEP_TRL_N):   cur_byte = CHAR_N;
			default:               cur_byte = ESC_BYTE;
		endcase
	end

	assign emit = head_valid && (!byte_valid_q || byte_ready);
	assign pop  = emit && final_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= '0;
			byte_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				byte_valid_q <= 1'b1;
				done_q       <= final_step ? '0 : (done_q | (step_mask_t'(1) << cur));
			end else if (byte_ready) begin
				byte_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= cur_byte;
			last_q      <= final_step;
			frame_end_q <= (cur == STEP_W'(STEP_TRL_N));
		end
	end

	assign byte_valid = byte_valid_q;
	assign out_byte   = out_byte_q;
	assign last       = last_q;
	assign frame_end  = frame_end_q;

endmodule

// File: sv/bilevel_run_length_encoder.sv
// Top level of the bilevel run-length encoder: mode register, front end, queue, back end.
// A pixel's command passes through the command queue, and each of its bytes through the output register.
// Throughput: one pixel per cycle while the four-entry command queue has room; the back
// end sends one byte per cycle while byte_ready does not stall it.
// Reset clears the frame mode to medium, the colour to set, the run and pixel count to zero,
// and empties the queue and the output register.
module bilevel_run_length_encoder import brle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       frame_mode,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  logic       dark,
	output logic       byte_valid,
	input  logic       byte_ready,
	output logic [7:0] out_byte,
	output logic       last,
	output logic       frame_end
);

	// The mode register takes every write beat at once; the header of a frame
	// keeps the mode seen at its first pixel, since it is captured per command.
	logic       mode_q;

	logic       push;
	logic       q_full;
	logic       q_head_valid;
	logic       q_pop;
	brle_cmd_t  push_cmd;
	brle_cmd_t  head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= frame_mode;
		end
	end

	// The front end classifies each pixel and decides which bytes it causes.
	// A pixel that continues a run without filling it, and neither opens nor closes the frame, pushes nothing.
	brle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.dark      (dark),
		.q_full    (q_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	// The queue absorbs header and trailer bursts so that the pixel side and
	// the byte side can stall on their own.
	brle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (q_head_valid),
		.pop        (q_pop),
		.head       (head)
	);

	// The back end sends the bytes of the head command in stream order through
	// an output register, and pops the command with its last byte.
	brle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.pop        (q_pop),
		.head       (head),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.out_byte   (out_byte),
		.last       (last),
		.frame_end  (frame_end)
	);

endmodule

// File: sv/brle_checker.sv
// Port-level checks for the bilevel run-length encoder and their binding.
module brle_checker import brle_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_ready,
	input logic [7:0] out_byte,
	input logic       last,
	input logic       frame_end
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(out_byte) && $stable(last)
			&& $stable(frame_end))
		else $error("output beat changed while stalled");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && frame_end |-> last && (out_byte == CHAR_N))
		else $error("frame end not on the closing trailer byte");

	a_esc_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && (out_byte == ESC_BYTE) |-> !last && !frame_end)
		else $error("escape byte closed a pixel's output");

endmodule

bind bilevel_run_length_encoder brle_checker u_brle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.out_byte   (out_byte),
	.last       (last),
	.frame_end  (frame_end)
);
